>>> rtl/core/bsr_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bsr_pkg: shared definitions for the backlight smoothing ramp
// Payload types, action and register codes, reset values and divider status.
// -----------------------------------------------------------------------------
package bsr_pkg;

   // default fixed-point format of the held levels
   localparam int DEF_FRACTION_BITS = 8;
   localparam int DEF_LEVEL_BITS    = 16;

   // width of the panel value fields and of the level registers
   localparam int FIELD_BITS = 16;

   // action codes
   localparam logic [1:0] ACT_RESET  = 2'd0;
   localparam logic [1:0] ACT_UPDATE = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_MIN_LEVEL      = 2'd0;
   localparam logic [1:0] CSR_FULL_LEVEL     = 2'd1;
   localparam logic [1:0] CSR_SNAP_THRESHOLD = 2'd2;
   localparam logic [1:0] CSR_STEP_INTERVAL  = 2'd3;

   // register reset values
   localparam logic [15:0] MIN_LEVEL_RESET  = 16'd300;
   localparam logic [15:0] FULL_LEVEL_RESET = 16'hffff;
   localparam logic [7:0]  SNAP_RESET       = 8'd2;
   localparam logic [7:0]  INTERVAL_RESET   = 8'd10;

   // each ramp step covers one twentieth of the remaining distance
   localparam logic [15:0] RAMP_DIVISOR = 16'd20;

   // largest reported brightness
   localparam logic [15:0] OUT_MAX = 16'hffff;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] level;
      logic [15:0] level_max;
   } bsr_req_type;

   typedef struct packed {
      logic [15:0] brightness;
      logic [7:0]  next_delay_ms;
   } bsr_rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bsr_div_status_type;

endpackage
`default_nettype wire

>>> rtl/core/bsr_stream_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bsr_stream_if: valid/ready channel
// Carries one item per accepted handshake; payload type set per instance.
// -----------------------------------------------------------------------------
interface bsr_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/core/bsr_serial_div.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bsr_serial_div: bit-serial restoring divider
// Produces one quotient bit per cycle; the dividend shifts out at the top while
// quotient bits shift in at the bottom of the same register.
// -----------------------------------------------------------------------------
module bsr_serial_div
   import bsr_pkg::*;
#(
   parameter int DIVIDEND_BITS = 32 + DEF_FRACTION_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [DIVIDEND_BITS-1:0]  dividend,
   input  wire logic [FIELD_BITS-1:0]     divisor,
   output      logic [DIVIDEND_BITS-1:0]  quotient,
   output      bsr_div_status_type        status
);
   localparam int CW = $clog2(DIVIDEND_BITS + 1);

   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [FIELD_BITS-1:0]    rem_ff, rem_in;
   logic [FIELD_BITS-1:0]    divisor_ff;
   logic [CW-1:0]            count_ff, count_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   logic [FIELD_BITS:0] trial;
   logic [FIELD_BITS:0] diff;
   logic                fits;

   // trial subtract of the next partial remainder
   assign trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   // advance one quotient bit, or load a new division
   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         count_in = CW'(DIVIDEND_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[DIVIDEND_BITS-2:0], fits};
         rem_in   = fits ? diff[FIELD_BITS-1:0] : trial[FIELD_BITS-1:0];
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   // hold the data path
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         divisor_ff <= divisor;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
`default_nettype wire

>>> rtl/core/bsr_rsp_stage.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bsr_rsp_stage: result register with rounding
// Rounds the fixed-point level half up, clamps it to 16 bits and holds the
// item until the consumer takes it.
// -----------------------------------------------------------------------------
module bsr_rsp_stage
   import bsr_pkg::*;
#(
   parameter int FRACTION_BITS = DEF_FRACTION_BITS,
   parameter int LEVEL_BITS    = DEF_LEVEL_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                load,
   input  wire logic [LEVEL_BITS+FRACTION_BITS-1:0] level,
   input  wire logic [7:0]                          delay,
   output      logic                                slot_free,
   bsr_stream_if.source                             rsp_chan
);
   localparam int LW = LEVEL_BITS + FRACTION_BITS;
   localparam int OW = (LEVEL_BITS + 1 > 17) ? LEVEL_BITS + 1 : 17;
   localparam logic [LW:0] ROUND_HALF = (LW + 1)'(1) << (FRACTION_BITS - 1);

   logic        rsp_valid_ff;
   bsr_rsp_type rsp_payload_ff;

   logic [LW:0]         sum;
   logic [OW-1:0]       whole;
   logic [FIELD_BITS-1:0] rounded;

   // round half up, then clamp to the output range
   assign sum     = {1'b0, level} + ROUND_HALF;
   assign whole   = OW'(sum[LW:FRACTION_BITS]);
   assign rounded = (whole > OW'(OUT_MAX)) ? OUT_MAX : whole[FIELD_BITS-1:0];

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // hold valid until the item is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // capture the payload
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_payload_ff.brightness    <= rounded;
         rsp_payload_ff.next_delay_ms <= delay;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      load |-> slot_free)
      else $error("result loaded over an item not yet taken");

endmodule
`default_nettype wire

>>> rtl/core/backlight_smooth_ramp_unit.sv
`default_nettype none
// -----------------------------------------------------------------------------
// backlight_smooth_ramp_unit: exponential smoothing ramp for a panel backlight
// Maps value/maximum to a target drive level and moves the drive level toward
// it by one twentieth of the distance per tick, snapping when close.
// -----------------------------------------------------------------------------
// One item is worked at a time; the next item is taken while a result still
// waits at the output. A reset or update whose value is below a nonzero
// maximum latches the item, forms the value-times-span product, runs the
// bit-serial divider, which yields one quotient bit per cycle, and then
// finishes the mapped level. A moving tick runs the same divider by 20. Ticks
// that snap, and resets or updates with a zero maximum or a value at or above
// the maximum, skip the divider. Action code three is taken and dropped.
// Levels are held with LEVEL_BITS integer and FRACTION_BITS fraction bits;
// both levels reset to the midpoint 32917.5.
// -----------------------------------------------------------------------------
module backlight_smooth_ramp_unit
   import bsr_pkg::*;
#(
   parameter int FRACTION_BITS = DEF_FRACTION_BITS,
   parameter int LEVEL_BITS    = DEF_LEVEL_BITS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   bsr_stream_if.sink        req_chan,
   bsr_stream_if.source      rsp_chan,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);
   localparam int LW = LEVEL_BITS + FRACTION_BITS;
   localparam int DW = 2 * FIELD_BITS + FRACTION_BITS;
   localparam int QW = FIELD_BITS + FRACTION_BITS;
   localparam int XW = (QW + 1 > LW + 1) ? QW + 1 : LW + 1;

   localparam logic [LW-1:0] FX_LIMIT = {{LEVEL_BITS{1'b1}}, {FRACTION_BITS{1'b0}}};
   localparam logic [XW-1:0] RESET_RAW =
      (XW'(MIN_LEVEL_RESET) << FRACTION_BITS) +
      (XW'(FULL_LEVEL_RESET - MIN_LEVEL_RESET) << (FRACTION_BITS - 1));
   localparam logic [LW-1:0] RESET_LEVEL =
      (RESET_RAW > XW'(FX_LIMIT)) ? FX_LIMIT : RESET_RAW[LW-1:0];

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_EMIT} state_type;

   // saturate a mapped level at the largest held level
   function automatic logic [LW-1:0] clamp_level(input logic [XW-1:0] raw);
      if (raw > XW'(FX_LIMIT)) begin
         return FX_LIMIT;
      end
      return raw[LW-1:0];
   endfunction

   // configuration registers
   logic [15:0] min_ff;
   logic [15:0] full_ff;
   logic [7:0]  snap_ff;
   logic [7:0]  interval_ff;

   // control and item state
   state_type   state_ff;
   logic [1:0]  action_ff;
   logic [15:0] num_ff;
   logic [15:0] den_ff;
   logic [15:0] span_ff;
   logic        tick_up_ff;
   logic [LW-1:0] pending_ff;
   logic [7:0]  delay_ff;
   logic [LW-1:0] current_ff;
   logic [LW-1:0] target_ff;

   // combinational helpers
   bsr_req_type req;
   logic        req_fire;
   logic        map_up;
   logic [15:0] span;
   logic [XW-1:0] base;
   logic [XW-1:0] top_level;
   logic          tick_up;
   logic [LW-1:0] tick_gap;
   logic [LW-1:0] thr;
   logic          tick_moves;
   logic [31:0]   prod;
   logic [QW-1:0] off;
   logic [XW-1:0] map_raw;
   logic [LW-1:0] step;
   logic [LW-1:0] tick_level;

   // divider and output stage hookup
   logic               div_start;
   logic [DW-1:0]      div_dividend;
   logic [15:0]        div_divisor;
   logic [DW-1:0]      div_quotient;
   bsr_div_status_type div_status;
   logic               rsp_load;
   logic               slot_free;

   assign req      = req_chan.payload;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;

   // mapping direction and span from the configured end points
   assign map_up    = (full_ff >= min_ff);
   assign span      = map_up ? (full_ff - min_ff) : (min_ff - full_ff);
   assign base      = XW'(min_ff) << FRACTION_BITS;
   assign top_level = XW'(full_ff) << FRACTION_BITS;

   // ramp distance against the snap threshold
   assign tick_up    = (target_ff >= current_ff);
   assign tick_gap   = tick_up ? (target_ff - current_ff) : (current_ff - target_ff);
   assign thr        = LW'(snap_ff) << FRACTION_BITS;
   assign tick_moves = (tick_gap > thr);

   // one multiply of the registered value and span feeds the divider
   assign prod = num_ff * span_ff;

   // finish the mapping or the ramp step from the quotient
   assign off        = div_quotient[QW-1:0];
   assign map_raw    = map_up ? (base + XW'(off)) : (base - XW'(off));
   assign step       = (div_quotient[LW-1:0] == '0) ? LW'(1) : div_quotient[LW-1:0];
   assign tick_level = tick_up_ff ? (current_ff + step) : (current_ff - step);

   // start the divider for a moving tick or after the multiply
   always_comb begin
      div_start    = 1'b0;
      div_dividend = DW'(prod) << FRACTION_BITS;
      div_divisor  = den_ff;
      if (state_ff == ST_MUL) begin
         div_start = 1'b1;
      end else if (req_fire && req.action == ACT_TICK && tick_moves) begin
         div_start    = 1'b1;
         div_dividend = DW'(tick_gap);
         div_divisor  = RAMP_DIVISOR;
      end
   end

   assign rsp_load = (state_ff == ST_EMIT) && (action_ff != ACT_UPDATE) && slot_free;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff      <= MIN_LEVEL_RESET;
         full_ff     <= FULL_LEVEL_RESET;
         snap_ff     <= SNAP_RESET;
         interval_ff <= INTERVAL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_LEVEL:      min_ff      <= csr_wdata;
            CSR_FULL_LEVEL:     full_ff     <= csr_wdata;
            CSR_SNAP_THRESHOLD: snap_ff     <= csr_wdata[7:0];
            CSR_STEP_INTERVAL:  interval_ff <= csr_wdata[7:0];
            default:            min_ff      <= min_ff;
         endcase
      end
   end

   // sequence one item and commit the ramp state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         current_ff <= RESET_LEVEL;
         target_ff  <= RESET_LEVEL;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  action_ff  <= req.action;
                  num_ff     <= req.level;
                  den_ff     <= req.level_max;
                  span_ff    <= span;
                  tick_up_ff <= tick_up;
                  delay_ff   <= 8'd0;
                  unique case (req.action)
                     ACT_RESET, ACT_UPDATE: begin
                        if (req.level_max == 16'd0) begin
                           pending_ff <= clamp_level(base);
                           state_ff   <= ST_EMIT;
                        end else if (req.level >= req.level_max) begin
                           pending_ff <= clamp_level(top_level);
                           state_ff   <= ST_EMIT;
                        end else begin
                           state_ff <= ST_MUL;
                        end
                     end
                     ACT_TICK: begin
                        if (tick_moves) begin
                           delay_ff <= interval_ff;
                           state_ff <= ST_DIV;
                        end else begin
                           pending_ff <= target_ff;
                           state_ff   <= ST_EMIT;
                        end
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_MUL: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_status.done) begin
                  pending_ff <= (action_ff == ACT_TICK) ? tick_level : clamp_level(map_raw);
                  state_ff   <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (action_ff == ACT_UPDATE) begin
                  target_ff <= pending_ff;
                  state_ff  <= ST_IDLE;
               end else if (slot_free) begin
                  current_ff <= pending_ff;
                  if (action_ff == ACT_RESET) begin
                     target_ff <= pending_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   bsr_serial_div #(
      .DIVIDEND_BITS (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   bsr_rsp_stage #(
      .FRACTION_BITS (FRACTION_BITS),
      .LEVEL_BITS    (LEVEL_BITS)
   ) u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .level     (pending_ff),
      .delay     (delay_ff),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

   a_accept_with_divider_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !div_status.busy)
      else $error("item accepted while the divider is busy");

   a_done_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_nonzero_divisor: assert property (@(posedge clock) disable iff (reset)
      div_start |-> div_divisor != 16'd0)
      else $error("divider started with a zero divisor");

   a_levels_in_range: assert property (@(posedge clock) disable iff (reset)
      !(current_ff > FX_LIMIT) && !(target_ff > FX_LIMIT))
      else $error("held level above the largest level");

endmodule
`default_nettype wire
